>>> rtl/sensorless_homing_supervisor_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sensorless homing supervisor
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef SENSORLESS_HOMING_SUPERVISOR_TOP_DEFINES_SVH
`define SENSORLESS_HOMING_SUPERVISOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is high.
`define SHS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds across reset.
`define SHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHS_ASSERT(lbl, clk, rst, prop, msg)
`define SHS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/shs_pkg.sv
// ---------------------------------------------------------------------------
// Sensorless homing supervisor package
// Shared types, event and mode codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package shs_pkg;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_TICK  = 3'd1,
    MODE_POLL  = 3'd2,
    MODE_ABORT = 3'd3,
    MODE_ESTOP = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    EV_STARTED     = 4'd0,
    EV_BUSY        = 4'd1,
    EV_OTHERMOTION = 4'd2,
    EV_TIMEOUT     = 4'd3,
    EV_POLLREQ     = 4'd4,
    EV_QUERYFAIL   = 4'd5,
    EV_FAILABORT   = 4'd6,
    EV_FLAGS       = 4'd7,
    EV_FAILED      = 4'd8,
    EV_COMPLETE    = 4'd9,
    EV_WARN        = 4'd10,
    EV_STOP        = 4'd11,
    EV_ESTOP       = 4'd12
  } event_t;

  // Configuration register indexes.
  localparam logic [7:0] CFG_OVERALL_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_POLL_SPACING    = 8'd1;
  localparam logic [7:0] CFG_FAILURE_LIMIT   = 8'd2;
  localparam logic [7:0] CFG_WARN_AFTER      = 8'd3;

  localparam logic [31:0] OVERALL_TIMEOUT_RST = 32'd60000;
  localparam logic [15:0] POLL_SPACING_RST    = 16'd250;
  localparam logic [7:0]  FAILURE_LIMIT_RST   = 8'd5;
  localparam logic [15:0] WARN_AFTER_RST      = 16'd3000;

  // Bit positions in the origin status byte.
  localparam int unsigned FLAG_RUNNING_BIT = 2;
  localparam int unsigned FLAG_FAILED_BIT  = 3;

  localparam logic [7:0] FAIL_COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [31:0] overall_timeout_ms;
    logic [15:0] poll_spacing_ms;
    logic [7:0]  failure_limit;
    logic [15:0] warn_after_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  axis_id;
    logic [31:0] now_ms;
    logic        other_motion_busy;
    logic        query_ok;
    logic [7:0]  flags;
  } in_item_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  out_axis;
    logic [7:0]  out_flags;
    logic [7:0]  failure_count;
    logic        last_of_run;
  } result_t;

endpackage

>>> rtl/shs_core.sv
// ---------------------------------------------------------------------------
// Sensorless homing supervisor core
// Run state registers and the single-pass update that turns one request into
// up to two result records.
// ---------------------------------------------------------------------------
module shs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  shs_pkg::in_item_t item,
  input  shs_pkg::cfg_t     cfg,
  output logic [1:0]        res_cnt,
  output shs_pkg::result_t  res0,
  output shs_pkg::result_t  res1
);

  logic        run_active, run_active_next;
  logic        saw_running, saw_running_next;
  logic        warned, warned_next;
  logic        have_flags, have_flags_next;
  logic [7:0]  run_axis, run_axis_next;
  logic [7:0]  previous_flags, previous_flags_next;
  logic [7:0]  failed_polls, failed_polls_next;
  logic [31:0] start_time, start_time_next;
  logic [31:0] last_poll_time, last_poll_time_next;

  logic [31:0] since_start;
  logic [31:0] since_poll;
  logic        running;
  logic        flag_changed;

  assign since_start  = item.now_ms - start_time;
  assign since_poll   = item.now_ms - last_poll_time;
  assign running      = item.flags[shs_pkg::FLAG_RUNNING_BIT];
  assign flag_changed = !have_flags || (item.flags != previous_flags);

  always_comb begin
    run_active_next     = run_active;
    saw_running_next    = saw_running;
    warned_next         = warned;
    have_flags_next     = have_flags;
    run_axis_next       = run_axis;
    previous_flags_next = previous_flags;
    failed_polls_next   = failed_polls;
    start_time_next     = start_time;
    last_poll_time_next = last_poll_time;
    res_cnt             = 2'd0;
    res0                = '0;
    res1                = '0;

    unique case (item.mode)
      shs_pkg::MODE_START: begin
        res_cnt = 2'd1;
        if (run_active) begin
          res0.event_res = shs_pkg::EV_BUSY;
          res0.out_axis  = run_axis;
        end else if (item.other_motion_busy) begin
          res0.event_res = shs_pkg::EV_OTHERMOTION;
          res0.out_axis  = item.axis_id;
        end else begin
          saw_running_next    = 1'b0;
          warned_next         = 1'b0;
          have_flags_next     = 1'b0;
          previous_flags_next = '0;
          failed_polls_next   = '0;
          last_poll_time_next = '0;
          run_axis_next       = item.axis_id;
          start_time_next     = item.now_ms;
          run_active_next     = 1'b1;
          res0.event_res      = shs_pkg::EV_STARTED;
          res0.out_axis       = item.axis_id;
        end
      end
      shs_pkg::MODE_TICK: begin
        if (run_active) begin
          if (since_start >= cfg.overall_timeout_ms) begin
            run_active_next = 1'b0;
            res_cnt         = 2'd1;
            res0.event_res  = shs_pkg::EV_TIMEOUT;
            res0.out_axis   = run_axis;
          end else if (since_poll >= {16'd0, cfg.poll_spacing_ms}) begin
            last_poll_time_next = item.now_ms;
            res_cnt             = 2'd1;
            res0.event_res      = shs_pkg::EV_POLLREQ;
            res0.out_axis       = run_axis;
          end
        end
      end
      shs_pkg::MODE_POLL: begin
        if (run_active && !item.query_ok) begin
          if (failed_polls != shs_pkg::FAIL_COUNT_MAX) begin
            failed_polls_next = failed_polls + 8'd1;
          end
          res_cnt        = 2'd1;
          res0.event_res = shs_pkg::EV_QUERYFAIL;
          res0.out_axis  = run_axis;
          if (failed_polls_next >= cfg.failure_limit) begin
            run_active_next = 1'b0;
            res_cnt         = 2'd2;
            res1.event_res  = shs_pkg::EV_FAILABORT;
            res1.out_axis   = run_axis;
          end
        end else if (run_active) begin
          failed_polls_next = '0;
          saw_running_next  = saw_running | running;
          if (flag_changed) begin
            previous_flags_next = item.flags;
            have_flags_next     = 1'b1;
            res_cnt             = 2'd1;
            res0.event_res      = shs_pkg::EV_FLAGS;
            res0.out_axis       = run_axis;
            res0.out_flags      = item.flags;
          end
          // The verdict record goes after the flag report when there is one.
          if (item.flags[shs_pkg::FLAG_FAILED_BIT]) begin
            run_active_next = 1'b0;
            res_cnt         = res_cnt + 2'd1;
            if (flag_changed) begin
              res1.event_res = shs_pkg::EV_FAILED;
              res1.out_axis  = run_axis;
            end else begin
              res0.event_res = shs_pkg::EV_FAILED;
              res0.out_axis  = run_axis;
            end
          end else if (saw_running_next && !running) begin
            run_active_next = 1'b0;
            res_cnt         = res_cnt + 2'd1;
            if (flag_changed) begin
              res1.event_res = shs_pkg::EV_COMPLETE;
              res1.out_axis  = run_axis;
            end else begin
              res0.event_res = shs_pkg::EV_COMPLETE;
              res0.out_axis  = run_axis;
            end
          end else if (!saw_running_next && !warned &&
                       (since_start >= {16'd0, cfg.warn_after_ms})) begin
            warned_next = 1'b1;
            res_cnt     = res_cnt + 2'd1;
            if (flag_changed) begin
              res1.event_res = shs_pkg::EV_WARN;
              res1.out_axis  = run_axis;
            end else begin
              res0.event_res = shs_pkg::EV_WARN;
              res0.out_axis  = run_axis;
            end
          end
        end
      end
      shs_pkg::MODE_ABORT: begin
        if (run_active && (run_axis == item.axis_id)) begin
          run_active_next = 1'b0;
        end
        res_cnt        = 2'd1;
        res0.event_res = shs_pkg::EV_STOP;
        res0.out_axis  = item.axis_id;
      end
      shs_pkg::MODE_ESTOP: begin
        run_active_next = 1'b0;
        res_cnt         = 2'd1;
        res0.event_res  = shs_pkg::EV_ESTOP;
      end
      default: begin
      end
    endcase

    res0.failure_count = failed_polls_next;
    res1.failure_count = failed_polls_next;
    res0.last_of_run   = (res_cnt == 2'd1);
    res1.last_of_run   = (res_cnt == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active     <= 1'b0;
      saw_running    <= 1'b0;
      warned         <= 1'b0;
      have_flags     <= 1'b0;
      run_axis       <= '0;
      previous_flags <= '0;
      failed_polls   <= '0;
      start_time     <= '0;
      last_poll_time <= '0;
    end else if (step) begin
      run_active     <= run_active_next;
      saw_running    <= saw_running_next;
      warned         <= warned_next;
      have_flags     <= have_flags_next;
      run_axis       <= run_axis_next;
      previous_flags <= previous_flags_next;
      failed_polls   <= failed_polls_next;
      start_time     <= start_time_next;
      last_poll_time <= last_poll_time_next;
    end
  end

endmodule

>>> rtl/shs_res_fifo.sv
// ---------------------------------------------------------------------------
// Sensorless homing supervisor result queue
// Four-entry queue that takes up to two result records per cycle and hands
// out one per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module shs_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  shs_pkg::result_t push0,
  input  shs_pkg::result_t push1,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_stall,
  output shs_pkg::result_t head
);

  shs_pkg::result_t mem [4];
  logic [1:0] wptr, rptr;
  logic [1:0] wptr_inc;
  logic [2:0] count, count_next;
  logic       pop;

  assign out_valid  = (count != 3'd0);
  assign pop        = out_valid && !out_stall;
  assign room2      = (count <= 3'd2);
  assign head       = mem[rptr];
  assign wptr_inc   = wptr + 2'd1;
  assign count_next = count + {1'b0, push_n} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push_n;
      rptr  <= rptr + {1'b0, pop};
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wptr_inc] <= push1;
    end
  end

endmodule

>>> rtl/sensorless_homing_supervisor_top.sv
// ---------------------------------------------------------------------------
// Sensorless homing supervisor
// Watches one axis through a homing run and reports start, poll, failure,
// completion and stop events.
// ---------------------------------------------------------------------------
// A request enters an input register on the cycle it is accepted and is
// evaluated against the run state once the queue can take two records, so a
// request can be taken on every clock while the queue has room. Each request
// yields zero, one or two result records (two only for a failed poll that
// reaches the failure limit, or for a flag report followed by a failed,
// complete or warning verdict). Results go into a four-entry queue that
// delivers one record per cycle while the output is not stalled; the input
// register holds its request (and the input stalls) whenever the queue has
// fewer than two free entries. With the output never stalled and one result
// per request the block sustains one request per cycle; requests that make
// two records outrun the single-record output and stall the input.
// The last record of each request carries last_of_run. Configuration writes
// are always ready and take effect on the next cycle; they are meant to be
// issued only while no request is in flight. All elapsed-time comparisons
// use wrapping 32-bit differences of the millisecond count.
// ---------------------------------------------------------------------------
`include "sensorless_homing_supervisor_top_defines.svh"

module sensorless_homing_supervisor_top (
  input  logic        clk,
  input  logic        rst,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [7:0]  axis_id,
  input  logic [31:0] now_ms,
  input  logic        other_motion_busy,
  input  logic        query_ok,
  input  logic [7:0]  flags,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_res,
  output logic [7:0]  out_axis,
  output logic [7:0]  out_flags,
  output logic [7:0]  failure_count,
  output logic        last_of_run,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  shs_pkg::cfg_t     cfg;
  shs_pkg::in_item_t in_q;
  logic              in_q_valid;
  logic              in_accept;
  logic              room2;
  logic              process;
  logic [1:0]        res_cnt;
  logic [1:0]        push_n;
  shs_pkg::result_t  res0, res1;
  shs_pkg::result_t  head;

  // Configuration registers; writes are accepted every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overall_timeout_ms <= shs_pkg::OVERALL_TIMEOUT_RST;
      cfg.poll_spacing_ms    <= shs_pkg::POLL_SPACING_RST;
      cfg.failure_limit      <= shs_pkg::FAILURE_LIMIT_RST;
      cfg.warn_after_ms      <= shs_pkg::WARN_AFTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        shs_pkg::CFG_OVERALL_TIMEOUT: cfg.overall_timeout_ms <= cfg_data;
        shs_pkg::CFG_POLL_SPACING:    cfg.poll_spacing_ms    <= cfg_data[15:0];
        shs_pkg::CFG_FAILURE_LIMIT:   cfg.failure_limit      <= cfg_data[7:0];
        shs_pkg::CFG_WARN_AFTER:      cfg.warn_after_ms      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // The held request is evaluated once the queue can take two records.
  assign process   = in_q_valid && room2;
  assign in_stall  = in_q_valid && !room2;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (process) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q.mode              <= mode;
      in_q.axis_id           <= axis_id;
      in_q.now_ms            <= now_ms;
      in_q.other_motion_busy <= other_motion_busy;
      in_q.query_ok          <= query_ok;
      in_q.flags             <= flags;
    end
  end

  shs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (process),
    .item    (in_q),
    .cfg     (cfg),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  assign push_n = process ? res_cnt : 2'd0;

  shs_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign event_res     = head.event_res;
  assign out_axis      = head.out_axis;
  assign out_flags     = head.out_flags;
  assign failure_count = head.failure_count;
  assign last_of_run   = head.last_of_run;

  // The queue comes out of reset empty.
  `SHS_ASSERT_ALWAYS(a_empty_after_rst, clk, rst |=> !out_valid, "results present after reset")

  // A request that cannot be evaluated stays in the input register unchanged.
  `SHS_ASSERT(a_hold_request, clk, rst, in_q_valid && !room2 |=> in_q_valid && $stable(in_q), "held request lost or changed")

  // Only the second of two records closes a request.
  `SHS_ASSERT(a_last_marks, clk, rst, process && (res_cnt == 2'd2) |-> res1.last_of_run && !res0.last_of_run, "last_of_run misplaced on a pair")

  // A single record always closes its request.
  `SHS_ASSERT(a_single_last, clk, rst, process && (res_cnt == 2'd1) |-> res0.last_of_run, "single record not marked last")

endmodule
